// ----- rtl/core/pnguf_pkg.sv -----
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared types and constants of the PNG scanline unfilter: payload structs,
// filter codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package pnguf_pkg;

   // Default sizes
   localparam int MAX_ROW_BYTES_DEF   = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 8;

   // Filter type codes
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // Highest legal filter type byte
   localparam logic [7:0] FILT_MAX_BYTE = 8'd4;

   // Configuration register indexes
   localparam logic CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic CSR_ROW_BYTES       = 1'b1;

   localparam int BPP_W      = 4;
   localparam int ROW_W      = 14;
   localparam int CSR_DATA_W = 14;

   // Request payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   // Result payload
   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       bad_filter;
   } rsp_type;

   // Operands of the byte predictor
   typedef struct packed {
      logic [2:0] filter;
      logic [7:0] data;
      logic [7:0] left;
      logic [7:0] up;
      logic [7:0] upleft;
   } pred_in_type;

endpackage

`default_nettype wire

// ----- rtl/core/pnguf_line_buf.sv -----
// ----------------------------------------------------------------------------
// pnguf_line_buf
// Previous-row byte store: one write port, one read port with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pnguf_line_buf #(
   parameter int DEPTH = pnguf_pkg::MAX_ROW_BYTES_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pnguf_predict.sv -----
// ----------------------------------------------------------------------------
// pnguf_predict
// Rebuilds one pixel byte: filtered byte plus the prediction chosen by the
// row's filter type (none, sub, up, average, Paeth), modulo 256.
// ----------------------------------------------------------------------------
`default_nettype none

module pnguf_predict (
   input  wire pnguf_pkg::pred_in_type op,
   output logic [7:0]                  rec
);

   logic signed [10:0] sa, sb, sc;
   logic signed [10:0] da, db, dc;
   logic        [9:0]  pa, pb, pc;
   logic        [7:0]  paeth;
   logic        [8:0]  avg_sum;
   logic        [7:0]  pred;

   // Paeth: distances of a+b-c to each neighbor
   always_comb begin
      sa = 11'(op.left);
      sb = 11'(op.up);
      sc = 11'(op.upleft);
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         paeth = op.left;
      end else if (pb <= pc) begin
         paeth = op.up;
      end else begin
         paeth = op.upleft;
      end
   end

   assign avg_sum = {1'b0, op.left} + {1'b0, op.up};

   // Prediction select
   always_comb begin
      case (op.filter)
         pnguf_pkg::FILT_SUB:   pred = op.left;
         pnguf_pkg::FILT_UP:    pred = op.up;
         pnguf_pkg::FILT_AVG:   pred = avg_sum[8:1];
         pnguf_pkg::FILT_PAETH: pred = paeth;
         default:               pred = 8'd0;
      endcase
   end

   assign rec = op.data + pred;

endmodule

`default_nettype wire

// ----- rtl/core/png_scanline_unfilter_unit.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG scanline filter reconstruction for a byte stream, with a previous-row
// line buffer and the none, sub, up, average and Paeth filters.
// ----------------------------------------------------------------------------
// Takes one request per clock unless results stall; a byte passes the input
// stage, where the line buffer read completes, then the result register. A
// row is a filter type byte then row_bytes filtered bytes; filter bytes
// give no result except when the type is above 4, which yields one result
// with bad_filter set and lets that row pass unchanged. frame_start on a
// request restarts row tracking; the first row of a frame sees zero above.
// The line buffer has one read and one write port and is not cleared: a row
// must not be longer than the row before it in the same frame. Configuration
// must be written only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_unit #(
   parameter int MAX_ROW_BYTES   = pnguf_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pnguf_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire pnguf_pkg::req_type               req_data,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output pnguf_pkg::rsp_type                    rsp_data,
   // configuration write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic                             csr_index,
   input  wire logic [pnguf_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int PW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int CW = $clog2(MAX_ROW_BYTES + 1);
   localparam int LW = (CW > pnguf_pkg::ROW_W) ? CW : pnguf_pkg::ROW_W;
   localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [pnguf_pkg::BPP_W-1:0] bpp_ff;
   logic [pnguf_pkg::ROW_W-1:0] row_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= pnguf_pkg::BPP_W'(4);
         row_ff <= pnguf_pkg::ROW_W'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pnguf_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_data[pnguf_pkg::BPP_W-1:0];
            pnguf_pkg::CSR_ROW_BYTES:       row_ff <= csr_data[pnguf_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped register values
   logic [pnguf_pkg::BPP_W-1:0] bpp_eff;
   logic [LW-1:0]               len_eff;

   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = pnguf_pkg::BPP_W'(1);
      end else if (32'(bpp_ff) > MAX_PIXEL_BYTES) begin
         bpp_eff = pnguf_pkg::BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = bpp_ff;
      end
      if (row_ff == '0) begin
         len_eff = LW'(1);
      end else if (32'(row_ff) > MAX_ROW_BYTES) begin
         len_eff = LW'(MAX_ROW_BYTES);
      end else begin
         len_eff = LW'(row_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: input stage advances when its byte gives no result or the result register is draining or free
   // ---------------------------------------------------------------------
   logic a_valid_ff;
   logic a_pixel_ff;
   logic a_bad_ff;
   logic a_go;
   logic a_emits;
   logic req_take;
   logic rsp_valid_ff;

   assign a_emits   = a_pixel_ff || a_bad_ff;
   assign a_go      = a_valid_ff && (!a_emits || !rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !a_go;
   assign req_take  = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Row tracking at acceptance
   // ---------------------------------------------------------------------
   logic [CW-1:0] col_ff, col_in, col_eff;
   logic [2:0]    filt_ff, filt_in;
   logic          first_ff, first_in, first_eff;
   logic          req_is_filter;
   logic          req_bad;
   logic          req_last;
   logic [PW-1:0] req_pos;

   always_comb begin
      col_eff       = req_data.frame_start ? '0 : col_ff;
      first_eff     = req_data.frame_start ? 1'b1 : first_ff;
      req_is_filter = (col_eff == '0);
      req_bad       = req_data.data_byte > pnguf_pkg::FILT_MAX_BYTE;
      req_last      = 32'(col_eff) >= 32'(len_eff);
      req_pos       = PW'(col_eff - CW'(1));

      col_in   = col_ff;
      filt_in  = filt_ff;
      first_in = first_ff;
      if (req_is_filter) begin
         col_in   = CW'(1);
         filt_in  = req_bad ? pnguf_pkg::FILT_NONE : req_data.data_byte[2:0];
         first_in = first_eff;
      end else if (req_last) begin
         col_in   = '0;
         first_in = 1'b0;
      end else begin
         col_in   = col_eff + CW'(1);
         first_in = first_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         filt_ff  <= pnguf_pkg::FILT_NONE;
         first_ff <= 1'b1;
      end else if (req_take) begin
         col_ff   <= col_in;
         filt_ff  <= filt_in;
         first_ff <= first_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input stage
   // ---------------------------------------------------------------------
   logic          a_first_ff;
   logic          a_last_ff;
   logic          a_clear_ff;
   logic [2:0]    a_filt_ff;
   logic [7:0]    a_data_ff;
   logic [PW-1:0] a_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_take) begin
         a_valid_ff <= 1'b1;
      end else if (a_go) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_pixel_ff <= !req_is_filter;
         a_bad_ff   <= req_is_filter && req_bad;
         a_clear_ff <= req_data.frame_start;
         a_first_ff <= first_eff;
         a_last_ff  <= req_last;
         a_filt_ff  <= filt_ff;
         a_data_ff  <= req_data.data_byte;
         a_pos_ff   <= req_pos;
      end
   end

   // Line buffer: read at acceptance, written as the pixel leaves the stage
   logic [7:0] above_q;
   logic [7:0] rec;

   pnguf_line_buf #(
      .DEPTH (MAX_ROW_BYTES),
      .AW    (PW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (a_go && a_pixel_ff),
      .wr_addr (a_pos_ff),
      .wr_data (rec),
      .rd_en   (req_take && !req_is_filter),
      .rd_addr (req_pos),
      .rd_data (above_q)
   );

   // ---------------------------------------------------------------------
   // Left and above-left histories, newest first
   // ---------------------------------------------------------------------
   logic [7:0]    left_hist_ff   [MAX_PIXEL_BYTES];
   logic [7:0]    upleft_hist_ff [MAX_PIXEL_BYTES];
   logic [HW-1:0] hist_idx;
   logic          left_ok;
   logic [7:0]    up_byte;

   assign hist_idx = HW'(bpp_eff - pnguf_pkg::BPP_W'(1));
   assign left_ok  = 32'(a_pos_ff) >= 32'(bpp_eff);
   assign up_byte  = a_first_ff ? 8'd0 : above_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_hist_ff[k]   <= 8'd0;
            upleft_hist_ff[k] <= 8'd0;
         end
      end else if (a_go && a_clear_ff) begin
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_hist_ff[k]   <= 8'd0;
            upleft_hist_ff[k] <= 8'd0;
         end
      end else if (a_go && a_pixel_ff) begin
         for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
            left_hist_ff[k]   <= left_hist_ff[k-1];
            upleft_hist_ff[k] <= upleft_hist_ff[k-1];
         end
         left_hist_ff[0]   <= rec;
         upleft_hist_ff[0] <= up_byte;
      end
   end

   // ---------------------------------------------------------------------
   // Byte reconstruction
   // ---------------------------------------------------------------------
   pnguf_pkg::pred_in_type pred_op;

   always_comb begin
      pred_op.filter = a_filt_ff;
      pred_op.data   = a_data_ff;
      pred_op.left   = left_ok ? left_hist_ff[hist_idx] : 8'd0;
      pred_op.up     = up_byte;
      pred_op.upleft = (left_ok && !a_first_ff) ? upleft_hist_ff[hist_idx] : 8'd0;
   end

   pnguf_predict u_predict (
      .op  (pred_op),
      .rec (rec)
   );

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   pnguf_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_go && a_emits) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && a_emits) begin
         rsp_data_ff.pixel      <= a_bad_ff ? 8'd0 : rec;
         rsp_data_ff.row_end    <= a_pixel_ff && a_last_ff;
         rsp_data_ff.bad_filter <= a_bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`ifndef SYNTH
   // A free result register never holds back requests
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with result register free");

   // The column counter never passes the row length limit
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) <= MAX_ROW_BYTES)
      else $error("column counter out of range");

   // An error result carries no pixel and no row end
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bad_filter |-> rsp_data_ff.pixel == 8'd0
         && !rsp_data_ff.row_end)
      else $error("error result carries pixel data");

   // A pixel leaving the input stage always lands in the result register
   a_pixel_lands: assert property (@(posedge clock) disable iff (reset)
      a_go && a_pixel_ff |=> rsp_valid_ff && !rsp_data_ff.bad_filter)
      else $error("pixel result lost");
`endif

endmodule

`default_nettype wire

// ----- tb/png_scanline_unfilter_unit_checker.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit_checker
// Watches the request, result and register channels of the PNG scanline
// unfilter, rebuilds every pixel byte itself from the accepted requests and
// the register writes, and compares each result with the oldest rebuilt byte.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit_checker #(
   parameter int LINE_BYTES  = pnguf_pkg::MAX_ROW_BYTES_DEF,
   parameter int PIXEL_BYTES = pnguf_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  pnguf_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  pnguf_pkg::rsp_type               rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [pnguf_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               fault_count,
   output int                               bytes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0]  BPP_AFTER_RESET = 4'd4;
   localparam logic [13:0] LEN_AFTER_RESET = 14'd4;
   localparam int          REPORT_LIMIT    = 10;

   // register copies
   logic [pnguf_pkg::BPP_W-1:0] cfg_bpp;
   logic [pnguf_pkg::ROW_W-1:0] cfg_len;

   // row tracking
   logic [7:0]  line_buf [LINE_BYTES];
   logic [7:0]  left_hist [PIXEL_BYTES];
   logic [7:0]  upleft_hist [PIXEL_BYTES];
   int unsigned col;
   logic [2:0]  row_filt;
   logic        first_row_flag;

   pnguf_pkg::rsp_type rebuilt_bytes [$];
   int                 mismatches = 0;

   // Paeth: pick whichever neighbor is closest to left + up - upleft
   function automatic logic [7:0] paeth_select(logic [7:0] a, logic [7:0] b,
                                               logic [7:0] c);
      int p;
      int da;
      int db;
      int dc;
      p  = int'(a) + int'(b) - int'(c);
      da = p - int'(a);
      db = p - int'(b);
      dc = p - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   function automatic void restart_frame();
      for (int k = 0; k < PIXEL_BYTES; k++) begin
         left_hist[k]   = 8'd0;
         upleft_hist[k] = 8'd0;
      end
      col            = 0;
      row_filt       = pnguf_pkg::FILT_NONE;
      first_row_flag = 1'b1;
   endfunction

   // Advance the row state by one request, queue the result it should produce, if any
   function automatic void unfilter_byte(pnguf_pkg::req_type r);
      int unsigned        bpp;
      int unsigned        len;
      int unsigned        pos;
      logic [7:0]         left;
      logic [7:0]         up;
      logic [7:0]         upleft;
      logic [7:0]         guess;
      logic [7:0]         rebuilt;
      logic [8:0]         sum9;
      logic               last;
      pnguf_pkg::rsp_type want;
      if (r.frame_start) restart_frame();

      // filter type byte: only a bad one gives a result
      if (col == 0) begin
         col = 1;
         if (r.data_byte > pnguf_pkg::FILT_MAX_BYTE) begin
            row_filt = pnguf_pkg::FILT_NONE;
            want.pixel      = 8'd0;
            want.row_end    = 1'b0;
            want.bad_filter = 1'b1;
            rebuilt_bytes.push_back(want);
         end else begin
            row_filt = r.data_byte[2:0];
         end
         return;
      end

      // out-of-range register values saturate
      bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > PIXEL_BYTES) ? PIXEL_BYTES : cfg_bpp);
      len = (cfg_len == 0) ? 1 : ((cfg_len > LINE_BYTES) ? LINE_BYTES : cfg_len);
      pos = col - 1;
      if (pos >= LINE_BYTES) pos = LINE_BYTES - 1;

      up     = first_row_flag ? 8'd0 : line_buf[pos];
      left   = (pos >= bpp) ? left_hist[bpp-1] : 8'd0;
      upleft = (pos >= bpp && !first_row_flag) ? upleft_hist[bpp-1] : 8'd0;

      case (row_filt)
         pnguf_pkg::FILT_SUB:   guess = left;
         pnguf_pkg::FILT_UP:    guess = up;
         pnguf_pkg::FILT_AVG: begin
            sum9  = {1'b0, left} + {1'b0, up};
            guess = sum9[8:1];
         end
         pnguf_pkg::FILT_PAETH: guess = paeth_select(left, up, upleft);
         default:               guess = 8'd0;
      endcase
      rebuilt = r.data_byte + guess;

      for (int k = PIXEL_BYTES - 1; k > 0; k--) begin
         left_hist[k]   = left_hist[k-1];
         upleft_hist[k] = upleft_hist[k-1];
      end
      left_hist[0]   = rebuilt;
      upleft_hist[0] = up;
      line_buf[pos]  = rebuilt;

      last = (pos + 1 >= len);
      if (last) begin
         col            = 0;
         first_row_flag = 1'b0;
      end else begin
         col = col + 1;
      end

      want.pixel      = rebuilt;
      want.row_end    = last;
      want.bad_filter = 1'b0;
      rebuilt_bytes.push_back(want);
   endfunction

   function automatic void compare_pixel(pnguf_pkg::rsp_type got);
      pnguf_pkg::rsp_type want;
      if (rebuilt_bytes.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result pixel %h row_end %b bad_filter %b",
                     $realtime, got.pixel, got.row_end, got.bad_filter);
         return;
      end
      want = rebuilt_bytes.pop_front();
      if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
          got.bad_filter !== want.bad_filter) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $write("%0t: result mismatch: expected pixel %h row_end %b bad_filter %b",
                   $realtime, want.pixel, want.row_end, want.bad_filter);
            $display(", got pixel %h row_end %b bad_filter %b",
                     got.pixel, got.row_end, got.bad_filter);
         end
      end
   endfunction

   // register writes first, then results, then the new request
   always @(posedge clock) begin
      if (reset) begin
         cfg_bpp = BPP_AFTER_RESET;
         cfg_len = LEN_AFTER_RESET;
         for (int k = 0; k < LINE_BYTES; k++) line_buf[k] = 8'd0;
         restart_frame();
         rebuilt_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == pnguf_pkg::CSR_BYTES_PER_PIXEL)
               cfg_bpp = csr_data[pnguf_pkg::BPP_W-1:0];
            else if (csr_index == pnguf_pkg::CSR_ROW_BYTES)
               cfg_len = csr_data[pnguf_pkg::ROW_W-1:0];
         end
         if (rsp_valid && !rsp_stall) compare_pixel(rsp_data);
         if (req_valid && !req_stall) unfilter_byte(req_data);
      end
      bytes_owed  <= rebuilt_bytes.size();
      fault_count <= mismatches;
   end

endmodule

// ----- tb/png_scanline_unfilter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit_tb
// Drives a PNG byte stream into the scanline unfilter: a directed pass over
// every filter type, bad type bytes and frame restarts, then random rows under
// a range of pixel sizes and row lengths, with sender gaps and result stalls.
// The checker beside the block rebuilds and compares every result.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 11;

   logic                             clock          = 1'b0;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_stall;
   pnguf_pkg::req_type               req_data       = '0;
   logic                             rsp_valid;
   logic                             rsp_stall      = 1'b0;
   pnguf_pkg::rsp_type               rsp_data;
   logic                             csr_valid      = 1'b0;
   logic                             csr_ready;
   logic                             csr_index      = pnguf_pkg::CSR_BYTES_PER_PIXEL;
   logic [pnguf_pkg::CSR_DATA_W-1:0] csr_data       = '0;

   int fault_count;
   int bytes_owed;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // shadow of the row position, keeps rows off never-written line entries
   int unsigned gen_col   = 0;
   logic        gen_first = 1'b1;
   int unsigned hwm       = 0;
   int unsigned cur_len   = 4;

   png_scanline_unfilter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   png_scanline_unfilter_unit_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fault_count (fault_count),
      .bytes_owed  (bytes_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("png_scanline_unfilter_unit_tb: errors");
         $finish;
      end
   end

   // result backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // one request, with a random gap ahead of it; updates the row shadow
   task automatic send_request(input logic [7:0] value, input logic fs);
      int unsigned pos;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.data_byte   <= value;
      req_data.frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      if (fs) begin
         gen_col   = 0;
         gen_first = 1'b1;
      end
      if (gen_col == 0) begin
         gen_col = 1;
      end else begin
         pos = gen_col - 1;
         if (pos + 1 > hwm) hwm = pos + 1;
         if (pos + 1 >= cur_len) begin
            gen_col   = 0;
            gen_first = 1'b0;
         end else begin
            gen_col = gen_col + 1;
         end
      end
   endtask

   // mostly well-formed rows; now and then a bad type or a frame restart
   task automatic send_random();
      logic       restart;
      logic       broken;
      logic       fs;
      logic [7:0] value;
      restart = !gen_first && cur_len > hwm;
      broken  = gen_col != 0 && $urandom_range(0, 79) == 0;
      fs      = restart || broken || (gen_col == 0 && $urandom_range(0, 11) == 0);
      if (fs || gen_col == 0) begin
         if ($urandom_range(0, 9) == 0) value = 8'($urandom_range(5, 255));
         else value = 8'($urandom_range(0, 4));
      end else begin
         case ($urandom_range(0, 7))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            2:       value = 8'($urandom_range(0, 3));
            default: value = 8'($urandom_range(0, 255));
         endcase
      end
      send_request(value, fs);
   endtask

   // stop sending and wait until every result is back and the pipe is empty
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx,
                            input logic [pnguf_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_config(input int bpp_val, input int len_val);
      csr_write(pnguf_pkg::CSR_BYTES_PER_PIXEL, pnguf_pkg::CSR_DATA_W'(bpp_val));
      csr_write(pnguf_pkg::CSR_ROW_BYTES, pnguf_pkg::CSR_DATA_W'(len_val));
      csr_valid <= 1'b0;
      if (len_val == 0) cur_len = 1;
      else if (len_val > pnguf_pkg::MAX_ROW_BYTES_DEF)
         cur_len = pnguf_pkg::MAX_ROW_BYTES_DEF;
      else cur_len = len_val;
   endtask

   // pixel size, row length and request count of each random phase;
   // zero values and the longest rows are kept short
   task automatic phase_plan(input int p, output int bpp_val, output int len_val,
                             output int items);
      case (p)
         0:       begin bpp_val = 1;  len_val = 1;     items = 60;  end
         1:       begin bpp_val = 8;  len_val = 16;    items = 120; end
         2:       begin bpp_val = 3;  len_val = 7;     items = 120; end
         3:       begin bpp_val = 0;  len_val = 0;     items = 40;  end
         4:       begin bpp_val = 15; len_val = 24;    items = 120; end
         5:       begin bpp_val = 2;  len_val = 9;     items = 120; end
         6:       begin bpp_val = 6;  len_val = 13;    items = 120; end
         7:       begin bpp_val = 8;  len_val = 8192;  items = 60;  end
         8:       begin bpp_val = 5;  len_val = 16383; items = 40;  end
         9:       begin bpp_val = 4;  len_val = 31;    items = 140; end
         default: begin bpp_val = 7;  len_val = 5;     items = 120; end
      endcase
   endtask

   initial begin
      int bpp_val;
      int len_val;
      int items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: one-byte pixels, two-byte rows
      write_config(1, 2);
      send_request(8'(pnguf_pkg::FILT_PAETH), 1'b1);   // Paeth on the first row uses left only
      send_request(8'hFF, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'(pnguf_pkg::FILT_SUB), 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'(pnguf_pkg::FILT_UP), 1'b0);
      send_request(8'h80, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'(pnguf_pkg::FILT_AVG), 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'(pnguf_pkg::FILT_PAETH), 1'b0);
      send_request(8'h10, 1'b0);
      send_request(8'hF0, 1'b0);
      send_request(8'hFF, 1'b0);            // bad type: row passes raw
      send_request(8'hAA, 1'b0);
      send_request(8'h55, 1'b0);
      send_request(pnguf_pkg::FILT_MAX_BYTE + 8'd1, 1'b0);
      send_request(8'(pnguf_pkg::FILT_NONE), 1'b1);    // restart where a pixel byte was due
      send_request(8'h01, 1'b0);
      send_request(8'h02, 1'b0);
      send_request(8'(pnguf_pkg::FILT_UP), 1'b0);
      send_request(8'h33, 1'b0);            // left mid-row; shorter rows end it next

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         phase_plan(p, bpp_val, len_val, items);
         quiesce();
         write_config(bpp_val, len_val);
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1:       begin send_idle_pct = 74; recv_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct <= 74; end
            default: begin send_idle_pct = 15; recv_stall_pct <= 15; end
         endcase
         for (int i = 0; i < items; i++) begin
            if (p % 3 == 1 && i == items / 2) quiesce();
            send_random();
         end
      end

      quiesce();
      if (fault_count == 0 && bytes_owed == 0) begin
         $display("png_scanline_unfilter_unit_tb: clean");
      end else begin
         $display("png_scanline_unfilter_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ----- png_scanline_unfilter_unit.f -----
rtl/core/pnguf_pkg.sv
rtl/core/pnguf_line_buf.sv
rtl/core/pnguf_predict.sv
rtl/core/png_scanline_unfilter_unit.sv
tb/png_scanline_unfilter_unit_checker.sv
tb/png_scanline_unfilter_unit_tb.sv
